@@ sv/arp_neighbor_cache_aging_top_macros.svh @@
// ----------------------------------------------------------------------------
// arp neighbor cache assertion macros
// concurrent checks on clk_i, disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef ARP_NEIGHBOR_CACHE_AGING_TOP_MACROS_SVH
`define ARP_NEIGHBOR_CACHE_AGING_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define ARPNC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define ARPNC_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define ARPNC_ASSERT(lbl, prop, msg)
`define ARPNC_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

@@ sv/arpnc_pkg.sv @@
// ----------------------------------------------------------------------------
// arpnc_pkg
// shared widths, codes and controller/datapath interface types
// ----------------------------------------------------------------------------
package arpnc_pkg;

  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned MAC_W      = 48;
  localparam int unsigned STAMP_W    = 32;
  localparam int unsigned AGE_W      = 16;
  localparam int unsigned PREFIX_W   = 6;
  localparam int unsigned SLOT_W     = 4;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [PREFIX_W-1:0] PREFIX_RST  = 6'd24;
  localparam logic [AGE_W-1:0]    MAX_AGE_RST = 16'd120;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDRESS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PREFIX_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_AGE       = 2'd2;

  typedef enum logic [KIND_W-1:0] {
    KIND_LEARN  = 2'd0,
    KIND_LOOKUP = 2'd1,
    KIND_TICK   = 2'd2
  } kind_e;

  typedef struct packed {
    logic [STAMP_W-1:0] stamp;
    logic [MAC_W-1:0]   mac;
    logic [ADDR_W-1:0]  addr;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic load;      // latch a new word
    logic prefetch;  // read the slot after the one under test
    logic advance;   // step to the next slot
    logic take;      // current slot wins: capture result, write on learn
  } cmd_t;

  typedef struct packed {
    logic needs_scan;  // incoming word is a lookup or an in-subnet learn
    logic match;       // slot under test qualifies
    logic last;        // slot under test is the final one
  } status_t;

endpackage

@@ sv/arpnc_ram.sv @@
// ----------------------------------------------------------------------------
// arpnc_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module arpnc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/arpnc_ctrl.sv @@
// ----------------------------------------------------------------------------
// arpnc_ctrl
// sequencer: accepts a word, drives the slot scan, presents the result
// ----------------------------------------------------------------------------
module arpnc_ctrl import arpnc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_FETCH = 4'b0010,
    ST_EVAL  = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = status_i.needs_scan ? ST_FETCH : ST_DONE;
        end
      end
      ST_FETCH: begin
        // slot zero read is in flight
        state_d = ST_EVAL;
      end
      ST_EVAL: begin
        cmd_o.prefetch = 1'b1;
        if (status_i.match) begin
          cmd_o.take = 1'b1;
          state_d    = ST_DONE;
        end else if (status_i.last) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.advance = 1'b1;
        end
      end
      ST_DONE: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ sv/arpnc_dp.sv @@
// ----------------------------------------------------------------------------
// arpnc_dp
// datapath: config registers, tick counter, neighbor table, slot tests
// ----------------------------------------------------------------------------
module arpnc_dp import arpnc_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [KIND_W-1:0]     kind_i,
  input  logic [ADDR_W-1:0]     query_addr_i,
  input  logic [MAC_W-1:0]      mac_in_i,
  input  cmd_t                  cmd_i,
  output status_t               status_o,
  output logic                  hit_o,
  output logic [MAC_W-1:0]      mac_out_o,
  output logic                  stored_o,
  output logic [SLOT_W-1:0]     slot_used_o
);

  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  logic [ADDR_W-1:0]        own_addr_q;
  logic [PREFIX_W-1:0]      prefix_q;
  logic [AGE_W-1:0]         max_age_q;
  logic [STAMP_W-1:0]       tick_q;
  logic [TABLE_ENTRIES-1:0] valid_q;
  logic [IDX_W-1:0]         idx_q;
  logic [KIND_W-1:0]        kind_q;
  logic [ADDR_W-1:0]        addr_q;
  logic [MAC_W-1:0]         mac_q;
  logic                     hit_q;
  logic [MAC_W-1:0]         mac_out_q;
  logic                     stored_q;
  logic [SLOT_W-1:0]        slot_q;

  // subnet test on the incoming word
  logic [PREFIX_W-1:0] len_w;
  logic [ADDR_W-1:0]   mask_w;
  logic                in_subnet_w;

  assign len_w       = (prefix_q > PREFIX_W'(ADDR_W)) ? PREFIX_W'(ADDR_W) : prefix_q;
  assign mask_w      = (len_w == '0) ? '0 : ('1 << (PREFIX_W'(ADDR_W) - len_w));
  assign in_subnet_w = ((query_addr_i ^ own_addr_q) & mask_w) == '0;

  assign status_o.needs_scan = ((kind_i == KIND_LEARN) && in_subnet_w) ||
                               (kind_i == KIND_LOOKUP);

  // table storage
  logic             ram_we;
  logic [IDX_W-1:0] ram_raddr;
  entry_t           ram_rdata;
  entry_t           ram_wdata;
  entry_t           ent;

  assign ram_raddr = (cmd_i.prefetch && (idx_q != LAST_IDX)) ? idx_q + 1'b1 : idx_q;

  arpnc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // never-written slots read as all zero
  assign ent = valid_q[idx_q] ? ram_rdata : '0;

  logic [STAMP_W-1:0] age_w;
  logic               fresh_w;
  logic               refresh_w;
  logic               overwrite_w;
  logic               lookup_hit_w;

  assign age_w        = tick_q - ent.stamp;
  assign fresh_w      = age_w <= STAMP_W'(max_age_q);
  assign refresh_w    = fresh_w && (ent.addr == addr_q);
  assign overwrite_w  = (ent.stamp == '0) || !fresh_w;
  assign lookup_hit_w = (ent.addr == addr_q) && fresh_w && (ent.mac != '0);

  assign status_o.match = (kind_q == KIND_LEARN) ? (refresh_w || overwrite_w) : lookup_hit_w;
  assign status_o.last  = idx_q == LAST_IDX;

  assign ram_we          = cmd_i.take && (kind_q == KIND_LEARN);
  assign ram_wdata.addr  = addr_q;
  assign ram_wdata.mac   = refresh_w ? ent.mac : mac_q;
  assign ram_wdata.stamp = tick_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_addr_q <= '0;
      prefix_q   <= PREFIX_RST;
      max_age_q  <= MAX_AGE_RST;
      tick_q     <= '0;
      valid_q    <= '0;
      idx_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_OWN_ADDRESS:   own_addr_q <= cfg_data_i;
          CFG_PREFIX_LENGTH: prefix_q   <= cfg_data_i[PREFIX_W-1:0];
          CFG_MAX_AGE:       max_age_q  <= cfg_data_i[AGE_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.load) begin
        idx_q <= '0;
        if (kind_i == KIND_TICK) begin
          tick_q <= tick_q + 1'b1;
        end
      end else if (cmd_i.advance) begin
        idx_q <= idx_q + 1'b1;
      end
      if (ram_we) begin
        valid_q[idx_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q    <= kind_i;
      addr_q    <= query_addr_i;
      mac_q     <= mac_in_i;
      hit_q     <= 1'b0;
      mac_out_q <= '0;
      stored_q  <= 1'b0;
      slot_q    <= '0;
    end else if (cmd_i.take) begin
      hit_q     <= kind_q == KIND_LOOKUP;
      mac_out_q <= (kind_q == KIND_LOOKUP) ? ent.mac : '0;
      stored_q  <= kind_q == KIND_LEARN;
      slot_q    <= SLOT_W'(idx_q);
    end
  end

  assign hit_o       = hit_q;
  assign mac_out_o   = mac_out_q;
  assign stored_o    = stored_q;
  assign slot_used_o = slot_q;

endmodule

@@ sv/arp_neighbor_cache_aging_top.sv @@
// ----------------------------------------------------------------------------
// arp_neighbor_cache_aging_top
// ipv4 to mac neighbor table with learn, lookup and age-based expiry
// ----------------------------------------------------------------------------
//  channel   direction  handshake                      contents
//  s_axis    in         s_axis_tvalid/s_axis_tready    tuser kind, tdata addr+mac
//  m_axis    out        m_axis_tvalid/m_axis_tready    tdata hit, mac, stored, slot
//  cfg       in         cfg_we_i (no wait)             cfg_index_i, cfg_data_i
//
// tick, unused kind and out-of-subnet learn: result valid the cycle after accept.
// lookup and in-subnet learn: a read of slot zero, then one slot tested per cycle
// through the table ram read port until a slot matches or the last slot is tested;
// at most TABLE_ENTRIES slots are tested.
// one word in flight: s_axis_tready is low until the result is taken.
// reset clears the table at once through per-slot valid bits, no sweep.
// ----------------------------------------------------------------------------
`include "arp_neighbor_cache_aging_top_macros.svh"

module arp_neighbor_cache_aging_top import arpnc_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [79:0]           s_axis_tdata,   // query_addr[31:0], mac_in[79:32]
  input  logic [KIND_W-1:0]     s_axis_tuser,   // kind[1:0]
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [55:0]           m_axis_tdata,   // hit[0], mac_out[48:1], stored[49],
                                                // slot_used[53:50], zero[55:54]
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cmd_t              cmd;
  status_t           status;
  logic              hit;
  logic [MAC_W-1:0]  mac_out;
  logic              stored;
  logic [SLOT_W-1:0] slot_used;

  arpnc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  arpnc_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .kind_i       (s_axis_tuser),
    .query_addr_i (s_axis_tdata[ADDR_W-1:0]),
    .mac_in_i     (s_axis_tdata[ADDR_W+MAC_W-1:ADDR_W]),
    .cmd_i        (cmd),
    .status_o     (status),
    .hit_o        (hit),
    .mac_out_o    (mac_out),
    .stored_o     (stored),
    .slot_used_o  (slot_used)
  );

  assign m_axis_tdata = {2'b00, slot_used, stored, mac_out, hit};

  `ARPNC_ASSERT_NEVER(a_one_word_in_flight, s_axis_tready && m_axis_tvalid, "input open while result pending")
  `ARPNC_ASSERT(a_tick_quick, s_axis_tvalid && s_axis_tready && (s_axis_tuser == KIND_TICK) |=> m_axis_tvalid, "tick result late")
  `ARPNC_ASSERT_NEVER(a_hit_and_stored, m_axis_tvalid && hit && stored, "hit and stored together")
  `ARPNC_ASSERT_NEVER(a_mac_without_hit, m_axis_tvalid && !hit && (mac_out != '0), "mac on a miss")

endmodule
